[hw/rtl/perm_enum_pkg.sv]
`default_nettype none

package perm_enum_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int IDX_W        = 3;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 4;
  localparam int TAB_W        = MAX_ELEMENTS * SYM_W;
  localparam int CFG_INDEX_W  = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_TABLE  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 4'd3;
  localparam logic [TAB_W-1:0] TAB_RESET = 64'h0000_0000_0063_6261;

  // controller to datapath
  typedef struct packed {
    logic load_identity;
    logic scan_init;
    logic scan_step;
    logic fill_step;
    logic pos_clear;
    logic emit_sym;
    logic emit_exh;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic pos_last;
    logic pos_zero;
    logic slot_free;
    logic fin;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/perm_enum_ctrl.sv]
`default_nettype none

module perm_enum_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_restart,
  output logic                 in_ready,
  input  wire                  cnt_wr,
  input  perm_enum_pkg::sts_t  sts,
  output perm_enum_pkg::cmd_t  cmd
);
  import perm_enum_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_EMIT,
    ST_EXH
  } state_t;

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic   done_r, done_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    done_nxt    = done_r;
    cmd         = '0;
    if (cnt_wr) begin
      started_nxt = 1'b0;
      done_nxt    = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart || !started_r) begin
            cmd.load_identity = 1'b1;
            state_nxt         = ST_EMIT;
          end else if (done_r) begin
            state_nxt = ST_EXH;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          if (sts.pos_last) begin
            cmd.pos_clear = 1'b1;
            state_nxt     = ST_EMIT;
          end else begin
            state_nxt = ST_FILL;
          end
        end else if (sts.pos_zero) begin
          done_nxt  = 1'b1;
          state_nxt = ST_EXH;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.pos_last) begin
          cmd.pos_clear = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_sym = 1'b1;
          if (sts.pos_last) begin
            started_nxt = 1'b1;
            done_nxt    = sts.fin;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_EXH: begin
        if (sts.slot_free) begin
          cmd.emit_exh = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      done_r    <= done_nxt;
    end
  end

  // a request after the final permutation goes straight to the exhausted word
  a_exh_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && !in_restart && started_r && done_r && !cnt_wr)
    |=> state_r == ST_EXH)
    else $error("exhausted request did not reach exhausted state");

  // a failed scan at position zero marks the enumeration done
  a_scan_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !sts.found && sts.pos_zero) |=> done_r)
    else $error("failed scan did not set done");

  // words are only loaded into a free output slot
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sym || cmd.emit_exh) |-> sts.slot_free)
    else $error("word loaded into a busy output slot");

endmodule

`default_nettype wire

[hw/rtl/perm_enum_dp.sv]
`default_nettype none

module perm_enum_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cnt_wr,
  input  wire                                    tab_wr,
  input  wire  [perm_enum_pkg::TAB_W-1:0]        cfg_data,
  input  perm_enum_pkg::cmd_t                    cmd,
  output perm_enum_pkg::sts_t                    sts,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [perm_enum_pkg::SYM_W-1:0]        out_symbol,
  output logic                                   out_last_in_run,
  output logic                                   out_final_permutation,
  output logic                                   out_exhausted
);
  import perm_enum_pkg::*;

  // lowest set bit: {found, index}
  function automatic logic [IDX_W:0] first_set(input logic [MAX_ELEMENTS-1:0] m);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (m[i]) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  logic [CNT_W-1:0]        cnt_r;
  logic [TAB_W-1:0]        tab_r;
  logic [IDX_W-1:0]        seq_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] free_r;
  logic [IDX_W-1:0]        pos_r;
  logic                    out_valid_r;
  logic [SYM_W-1:0]        out_symbol_r;
  logic                    out_last_r;
  logic                    out_fin_r;
  logic                    out_exh_r;

  logic [CNT_W-1:0]        n_c;
  logic [CNT_W-1:0]        nm1_c;
  logic [IDX_W-1:0]        last_pos_c;
  logic [IDX_W-1:0]        cur_c;
  logic [MAX_ELEMENTS-1:0] free_rel_c;
  logic [IDX_W:0]          cand_c;
  logic [IDX_W:0]          fill_c;
  logic                    fin_c;

  // clamp count to 1..MAX_ELEMENTS
  always_comb begin
    if (cnt_r == '0) n_c = CNT_W'(1);
    else if (cnt_r > CNT_W'(MAX_ELEMENTS)) n_c = CNT_W'(MAX_ELEMENTS);
    else n_c = cnt_r;
  end
  assign nm1_c      = n_c - CNT_W'(1);
  assign last_pos_c = nm1_c[IDX_W-1:0];

  assign cur_c      = seq_r[pos_r];
  assign free_rel_c = free_r | (MAX_ELEMENTS'(1) << cur_c);
  assign cand_c     = first_set(free_rel_c & (~MAX_ELEMENTS'(1) << cur_c));
  assign fill_c     = first_set(free_r);

  // final when the active prefix is strictly descending
  always_comb begin
    fin_c = 1'b1;
    for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
      if ((CNT_W'(k + 1) < n_c) && (seq_r[k] < seq_r[k+1])) fin_c = 1'b0;
    end
  end

  assign sts.found     = cand_c[IDX_W];
  assign sts.pos_last  = (pos_r == last_pos_c);
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.fin       = fin_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
      tab_r <= TAB_RESET;
      for (int k = 0; k < MAX_ELEMENTS; k++) seq_r[k] <= IDX_W'(k);
      out_valid_r <= 1'b0;
    end else begin
      if (cnt_wr) cnt_r <= cfg_data[CNT_W-1:0];
      if (tab_wr) tab_r <= cfg_data;

      if (cnt_wr || cmd.load_identity) begin
        for (int k = 0; k < MAX_ELEMENTS; k++) seq_r[k] <= IDX_W'(k);
      end else if (cmd.scan_step && cand_c[IDX_W]) begin
        seq_r[pos_r] <= cand_c[IDX_W-1:0];
      end else if (cmd.fill_step) begin
        seq_r[pos_r] <= fill_c[IDX_W-1:0];
      end

      if (cmd.emit_sym || cmd.emit_exh) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // scan state and output payload
  always_ff @(posedge clk) begin
    if (cmd.pos_clear || cmd.load_identity) pos_r <= '0;
    else if (cmd.scan_init) pos_r <= last_pos_c;
    else if (cmd.scan_step) pos_r <= cand_c[IDX_W] ? pos_r + IDX_W'(1) : pos_r - IDX_W'(1);
    else if (cmd.fill_step || cmd.emit_sym) pos_r <= pos_r + IDX_W'(1);

    if (cmd.scan_init) free_r <= '0;
    else if (cmd.scan_step) begin
      free_r <= cand_c[IDX_W] ? (free_rel_c & ~(MAX_ELEMENTS'(1) << cand_c[IDX_W-1:0]))
                              : free_rel_c;
    end else if (cmd.fill_step) begin
      free_r <= free_r & ~(MAX_ELEMENTS'(1) << fill_c[IDX_W-1:0]);
    end

    if (cmd.emit_sym) begin
      out_symbol_r <= tab_r[SYM_W*cur_c +: SYM_W];
      out_last_r   <= (pos_r == last_pos_c);
      out_fin_r    <= fin_c;
      out_exh_r    <= 1'b0;
    end else if (cmd.emit_exh) begin
      out_symbol_r <= '0;
      out_last_r   <= 1'b1;
      out_fin_r    <= 1'b0;
      out_exh_r    <= 1'b1;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_symbol            = out_symbol_r;
  assign out_last_in_run       = out_last_r;
  assign out_final_permutation = out_fin_r;
  assign out_exhausted         = out_exh_r;

endmodule

`default_nettype wire

[hw/rtl/permutation_enumerator_core.sv]
// start: a restart or first request emits the identity order, one after the final
//   order the exhausted word; others scan back and refill, then emit or exhaust
// scan: walks back through the index sequence, then refills the tail,
//   moving one position per cycle
// throughput: a new request is taken only when idle, after the last word of the run
//   is loaded; the words leave one per cycle while the output is not stalled
// reset: rst_n synchronous active low, count 3, identity order, not started
`default_nettype none

module permutation_enumerator_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_restart,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [perm_enum_pkg::SYM_W-1:0]      out_symbol,
  output logic                                 out_last_in_run,
  output logic                                 out_final_permutation,
  output logic                                 out_exhausted,
  // configuration write port
  input  wire                                  cfg_wr_en,
  input  wire  [perm_enum_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [perm_enum_pkg::TAB_W-1:0]      cfg_data
);
  import perm_enum_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cnt_wr;
  logic tab_wr;

  // register decode: a count write also rewinds the enumeration
  assign cnt_wr = cfg_wr_en && (cfg_index == REG_ELEMENT_COUNT);
  assign tab_wr = cfg_wr_en && (cfg_index == REG_SYMBOL_TABLE);

  // controller: idle / scan back / refill tail / emit word run / exhausted word
  perm_enum_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .cnt_wr     (cnt_wr),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: config registers, index sequence, free mask, position, output word
  perm_enum_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cnt_wr                (cnt_wr),
    .tab_wr                (tab_wr),
    .cfg_data              (cfg_data),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_symbol            (out_symbol),
    .out_last_in_run       (out_last_in_run),
    .out_final_permutation (out_final_permutation),
    .out_exhausted         (out_exhausted)
  );

endmodule

`default_nettype wire

[tb/permutation_enumerator_core_tb.sv]
`timescale 1ns / 100ps

module permutation_enumerator_core_tb;
  import perm_enum_pkg::*;

  localparam int RANDOM_ITEMS = 240;
  localparam int QUIET_ITEMS  = 40;     // last stretch runs with no idling
  localparam int LONG_HOLD    = 120;    // receiver back-pressure stretch, in cycles
  localparam int TAIL_CYCLES  = 30;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TIMEOUT_NS   = 2_000_000;

  // one result word as seen on the output channel
  typedef struct {
    logic [SYM_W-1:0] symbol;
    bit               last_in_run;
    bit               final_perm;
    bit               exhausted;
  } perm_word_t;

  // predicts the permutation words and checks them against the block
  class perm_scoreboard;
    logic [CNT_W-1:0] count_reg;
    logic [TAB_W-1:0] sym_table;
    logic [IDX_W-1:0] order [MAX_ELEMENTS];
    bit               started;
    bit               finished;
    perm_word_t       expected_words [$];
    int               mismatches;

    function new();
      count_reg  = CNT_RESET;
      sym_table  = TAB_RESET;
      started    = 1'b0;
      finished   = 1'b0;
      mismatches = 0;
      load_identity();
    endfunction

    function void load_identity();
      for (int k = 0; k < MAX_ELEMENTS; k++) order[k] = IDX_W'(k);
    endfunction

    function int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_ELEMENTS) return MAX_ELEMENTS;
      return int'(count_reg);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // backtrack from the tail: free indices, take the next larger free one,
    // then refill the tail in ascending order
    function bit step_order(int n);
      bit [MAX_ELEMENTS-1:0] taken;
      int q;
      taken = '0;
      for (int k = 0; k < n; k++) taken[k] = 1'b1;
      for (int p = n - 1; p >= 0; p--) begin
        taken[order[p]] = 1'b0;
        for (int j = order[p] + 1; j < n; j++) begin
          if (!taken[j]) begin
            order[p] = IDX_W'(j);
            taken[j] = 1'b1;
            q = p + 1;
            for (int v = 0; v < n && q < n; v++) begin
              if (!taken[v]) begin
                order[q] = IDX_W'(v);
                taken[v] = 1'b1;
                q++;
              end
            end
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void emit_order(int n);
      perm_word_t w;
      bit         is_last;
      is_last = 1'b1;
      for (int k = 0; k + 1 < n; k++)
        if (order[k] < order[k + 1]) is_last = 1'b0;
      for (int k = 0; k < n; k++) begin
        w.symbol      = sym_table[SYM_W * order[k] +: SYM_W];
        w.last_in_run = (k == n - 1);
        w.final_perm  = is_last;
        w.exhausted   = 1'b0;
        expected_words.push_back(w);
      end
      started  = 1'b1;
      finished = is_last;
    endfunction

    function void note_request(bit restart);
      perm_word_t w;
      int         n;
      n = active_count();
      if (restart || !started) begin
        load_identity();
        emit_order(n);
      end else if (finished) begin
        w = '{symbol: '0, last_in_run: 1'b1, final_perm: 1'b0, exhausted: 1'b1};
        expected_words.push_back(w);
      end else if (!step_order(n)) begin
        finished = 1'b1;
        w = '{symbol: '0, last_in_run: 1'b1, final_perm: 1'b0, exhausted: 1'b1};
        expected_words.push_back(w);
      end else begin
        emit_order(n);
      end
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [TAB_W-1:0] data);
      if (idx == REG_ELEMENT_COUNT) begin
        count_reg = data[CNT_W-1:0];
        load_identity();
        started  = 1'b0;
        finished = 1'b0;
      end else if (idx == REG_SYMBOL_TABLE) begin
        sym_table = data;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [SYM_W-1:0] symbol, logic last_in_run, logic final_perm,
                      logic exhausted);
      perm_word_t w;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending, symbol %h", symbol));
      end else begin
        w = expected_words.pop_front();
        if (symbol !== w.symbol)
          report_mismatch($sformatf("symbol %h, want %h", symbol, w.symbol));
        if (last_in_run !== w.last_in_run)
          report_mismatch($sformatf("last_in_run %b, want %b", last_in_run, w.last_in_run));
        if (final_perm !== w.final_perm)
          report_mismatch($sformatf("final_permutation %b, want %b", final_perm,
                                    w.final_perm));
        if (exhausted !== w.exhausted)
          report_mismatch($sformatf("exhausted %b, want %b", exhausted, w.exhausted));
      end
    endtask
  endclass

  // dut ports, all inputs known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_restart = 1'b0;
  logic                   out_ready  = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [TAB_W-1:0]       cfg_data   = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic [SYM_W-1:0]       out_symbol;
  logic                   out_last_in_run;
  logic                   out_final_permutation;
  logic                   out_exhausted;

  perm_scoreboard sb = new();

  // idling controls shared between the stimulus and the result sink
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  int hold_req_cnt = 0;

  permutation_enumerator_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_restart            (in_restart),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_symbol            (out_symbol),
    .out_last_in_run       (out_last_in_run),
    .out_final_permutation (out_final_permutation),
    .out_exhausted         (out_exhausted),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TAB_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request word, with an optional idle burst in front of it
  task automatic send_request(input bit restart);
    int gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_request(restart);
  endtask

  // stop offering and wait until every predicted word came out
  task automatic drain_words();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result sink: checks accepted words and drives out_ready
  initial begin : result_sink
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_symbol, out_last_in_run, out_final_permutation, out_exhausted);
      // long hold-off requested by the stimulus, short random bursts otherwise
      if (hold_req_cnt != holds_done) begin
        holds_done = hold_req_cnt;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int random_sent;
    int pick;
    int cur_count;
    int eff;
    int len;
    int perms;
    int restart_odds;
    int guard;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: three symbols, walk the whole enumeration, then past its end
    repeat (6) send_request(1'b0);
    send_request(1'b0);                 // exhausted word
    send_request(1'b1);                 // restart leaves the exhausted state
    send_request(1'b0);
    drain_words();

    // symbol table rewritten in the middle keeps the position
    write_reg(REG_SYMBOL_TABLE, {TAB_W{1'b1}});
    send_request(1'b0);
    drain_words();
    write_reg(REG_SYMBOL_TABLE, '0);
    send_request(1'b0);
    drain_words();

    // single element: identity is already the final order
    write_reg(REG_SYMBOL_TABLE, 64'h8877_6655_4433_2211);
    write_reg(REG_ELEMENT_COUNT, 64'd1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();

    // count zero behaves as one
    write_reg(REG_ELEMENT_COUNT, 64'd0);
    send_request(1'b0);
    send_request(1'b0);
    drain_words();

    // count above the maximum behaves as eight
    write_reg(REG_ELEMENT_COUNT, 64'd15);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();

    // two elements, run out and restart
    write_reg(REG_ELEMENT_COUNT, 64'd2);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_words();
    cur_count = 2;

    // random phases, mostly whole enumerations of small sets
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      restart_odds = 20;
      pick = $urandom_range(0, 11);

      case ($urandom_range(0, 7))
        0:       write_reg(REG_SYMBOL_TABLE, {TAB_W{1'b1}});
        1:       write_reg(REG_SYMBOL_TABLE, '0);
        2, 3, 4: write_reg(REG_SYMBOL_TABLE, {$urandom, $urandom});
        default: ;
      endcase

      if (random_sent == 0) begin
        // full set under a long receiver stall so the block backs up into its input
        cur_count = 8;
        write_reg(REG_ELEMENT_COUNT, 64'(cur_count));
        hold_req_cnt <= hold_req_cnt + 1;
        len = 20;
      end else if (pick < 2) begin
        // carry on from where the enumeration stands, new symbols
        write_reg(REG_SYMBOL_TABLE, {$urandom, $urandom});
        len = $urandom_range(2, 10);
      end else begin
        if (pick < 9) begin
          cur_count = $urandom_range(1, 4);
        end else if (pick < 11) begin
          cur_count = $urandom_range(5, 8);
        end else begin
          cur_count = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
          restart_odds = 3;
        end
        write_reg(REG_ELEMENT_COUNT, 64'(cur_count));
        eff = sb.active_count();
        perms = 1;
        for (int k = 2; k <= eff; k++) perms = perms * k;
        // small sets run to exhaustion and a little past it
        len = (eff <= 4) ? perms + $urandom_range(1, 3) : $urandom_range(4, 16);
      end

      for (int k = 0; k < len; k++)
        send_request($urandom_range(0, restart_odds - 1) == 0);
      random_sent += len;
      drain_words();
    end

    // final drain with a bound, then let any stray word show up
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d words never arrived", sb.pending()));

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
